FILE: sv/sre_pkg.sv
package sre_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int BASE_LEN_W  = 5;
  localparam int CHAR_W      = 8;
  localparam int TABLE_W     = 2 * CFG_DATA_W;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LENGTH  = 2'd2;

  // Reserved characters
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Quotient bits resolved per divider cycle
  localparam int DIV_STEP_BITS = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } sre_state_t;

  typedef struct packed {
    logic load_num;
    logic init;
    logic div_step;
    logic load_sign;
    logic load_err;
    logic emit;
  } sre_cmd_t;

  typedef struct packed {
    logic neg;
    logic digit_done;
    logic quot_zero;
    logic last_digit;
    logic out_free;
  } sre_sts_t;

endpackage

FILE: sv/sre_cfg.sv
module sre_cfg
  import sre_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [TABLE_W-1:0]     symbol_table,
  output logic [BASE_LEN_W-1:0]  base_length,
  output logic                   base_ok
);

  logic [CFG_DATA_W-1:0] symbols_low_r;
  logic [CFG_DATA_W-1:0] symbols_high_r;
  logic [BASE_LEN_W-1:0] base_length_r;
  logic                  bad_symbol;
  logic                  len_ok;

  assign cfg_ready = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
      base_length_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYMBOLS_LOW:  symbols_low_r  <= cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high_r <= cfg_data;
        CFG_BASE_LENGTH:  base_length_r  <= cfg_data[BASE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign symbol_table = {symbols_high_r, symbols_low_r};
  assign base_length  = base_length_r;

  // Flag reserved or repeated symbols among those in use
  always_comb begin
    bad_symbol = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (base_length_r > BASE_LEN_W'(i)) begin
        if (symbol_table[i*CHAR_W +: CHAR_W] == CHAR_PLUS ||
            symbol_table[i*CHAR_W +: CHAR_W] == CHAR_MINUS) begin
          bad_symbol = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (base_length_r > BASE_LEN_W'(j) &&
              symbol_table[i*CHAR_W +: CHAR_W] == symbol_table[j*CHAR_W +: CHAR_W]) begin
            bad_symbol = 1'b1;
          end
        end
      end
    end
  end

  assign len_ok  = (base_length_r >= BASE_LEN_W'(2)) &&
                   (base_length_r <= BASE_LEN_W'(MAX_SYMBOLS));
  assign base_ok = len_ok && !bad_symbol;

endmodule

FILE: sv/sre_ctrl.sv
module sre_ctrl
  import sre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     base_ok,
  input  sre_sts_t sts,
  output sre_cmd_t cmd
);

  sre_state_t state_r;
  sre_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = base_ok ? ST_DIV : ST_ERR;
      end
      ST_DIV: begin
        if (sts.digit_done && sts.quot_zero) state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        if (!sts.neg || sts.out_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.last_digit) state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_num = in_valid;
      end
      ST_CHECK: cmd.init      = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_SIGN:  cmd.load_sign = sts.neg && sts.out_free;
      ST_EMIT:  cmd.emit      = sts.out_free;
      ST_ERR:   cmd.load_err  = sts.out_free;
      default: ;
    endcase
  end

endmodule

FILE: sv/sre_dp.sv
module sre_dp
  import sre_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [NUMBER_BITS-1:0] in_number,
  input  logic [TABLE_W-1:0]     symbol_table,
  input  logic [BASE_LEN_W-1:0]  base_length,
  input  sre_cmd_t               cmd,
  output sre_sts_t               sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_character,
  output logic                   out_base_error,
  output logic                   out_is_last
);

  localparam int DIG_W   = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CHUNKS  = (NUMBER_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PAD     = CHUNKS * DIV_STEP_BITS;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DEPTH_W = $clog2(NUMBER_BITS + 1);

  logic [NUMBER_BITS-1:0]   num_r;
  logic                     neg_r;
  logic [PAD-1:0]           mag_r;
  logic [DIG_W-1:0]         rem_r;
  logic [CHUNK_W-1:0]       chunk_r;
  logic [DEPTH_W-1:0]       depth_r;
  logic [DIG_W-1:0]         digit_r [NUMBER_BITS];
  logic                     out_valid_r;
  logic [CHAR_W-1:0]        out_char_r;
  logic                     out_err_r;
  logic                     out_last_r;

  logic [DIG_W:0]           base;
  logic [NUMBER_BITS-1:0]   num_mag;
  logic [PAD-1:0]           mag_step;
  logic [DIG_W-1:0]         rem_step;
  logic [DIV_STEP_BITS-1:0] qbits;
  logic                     chunk_last;
  logic                     out_free;
  logic [CHAR_W-1:0]        top_symbol;

  // A valid base never exceeds MAX_SYMBOLS, so it fits DIG_W+1 bits
  assign base    = base_length[DIG_W:0];
  assign num_mag = num_r[NUMBER_BITS-1] ? (~num_r + NUMBER_BITS'(1)) : num_r;

  // Resolve one chunk of quotient bits by restoring division
  always_comb begin
    logic [DIG_W:0] t;
    logic [DIG_W:0] r;
    r = {1'b0, rem_r};
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      t = {r[DIG_W-1:0], mag_r[PAD-1-k]};
      if (t >= base) begin
        t = t - base;
        qbits[DIV_STEP_BITS-1-k] = 1'b1;
      end else begin
        qbits[DIV_STEP_BITS-1-k] = 1'b0;
      end
      r = t;
    end
    rem_step = r[DIG_W-1:0];
    mag_step = (mag_r << DIV_STEP_BITS) | PAD'(qbits);
  end

  assign chunk_last = (chunk_r == CHUNK_W'(CHUNKS - 1));
  assign out_free   = !out_valid_r || out_ready;
  assign top_symbol = symbol_table[{4'(digit_r[0]), 3'b000} +: CHAR_W];

  assign sts.neg        = neg_r;
  assign sts.digit_done = chunk_last;
  assign sts.quot_zero  = (mag_step == '0);
  assign sts.last_digit = (depth_r == DEPTH_W'(1));
  assign sts.out_free   = out_free;

  // Capture the input value
  always_ff @(posedge clk) begin
    if (cmd.load_num) begin
      num_r <= in_number;
    end
  end

  // Divider state: magnitude, remainder, chunk counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
    end else if (cmd.init) begin
      chunk_r <= '0;
    end else if (cmd.div_step) begin
      chunk_r <= chunk_last ? '0 : chunk_r + CHUNK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      neg_r <= num_r[NUMBER_BITS-1];
      mag_r <= PAD'(num_mag);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      mag_r <= mag_step;
      rem_r <= chunk_last ? '0 : rem_step;
    end
  end

  // Digit stack: push least significant first, pop most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.init) begin
      depth_r <= '0;
    end else if (cmd.div_step && chunk_last) begin
      depth_r <= depth_r + DEPTH_W'(1);
    end else if (cmd.emit) begin
      depth_r <= depth_r - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && chunk_last) begin
      digit_r[0] <= rem_step;
      for (int i = 1; i < NUMBER_BITS; i++) begin
        digit_r[i] <= digit_r[i-1];
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < NUMBER_BITS - 1; i++) begin
        digit_r[i] <= digit_r[i+1];
      end
      digit_r[NUMBER_BITS-1] <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_sign || cmd.load_err || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sign) begin
      out_char_r <= CHAR_MINUS;
      out_err_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.load_err) begin
      out_char_r <= '0;
      out_err_r  <= 1'b1;
      out_last_r <= 1'b1;
    end else if (cmd.emit) begin
      out_char_r <= top_symbol;
      out_err_r  <= 1'b0;
      out_last_r <= (depth_r == DEPTH_W'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_base_error = out_err_r;
  assign out_is_last    = out_last_r;

endmodule

FILE: sv/signed_radix_digit_emitter.sv
// Signed integer to text converter with a configurable digit alphabet.
//
// Channels: in_* takes one signed NUMBER_BITS value per beat; out_* delivers
// one character per beat, flagged with out_is_last on the final one; cfg_*
// writes the symbol table (index 0 low symbols, 1 high symbols) and the base
// length (index 2). cfg_ready is always high; the user must make writes land
// only while idle, as the block itself does not enforce it.
// An item is converted by a divider that resolves 8 quotient bits per cycle,
// so each digit needs one pass over every chunk of the padded magnitude. An
// invalid base gives one error beat. A minus sign, if any, is loaded into the
// output register in the sign state once the digit loop ends, and the first
// digit in the emit state that follows.
//
// Reset clears the configuration to zero (an invalid base) and drops any
// pending beat. When the receiver stalls, the current character holds in the
// output register and emission pauses, though division does not; the next
// input is taken while the final character of the previous one still waits.
module signed_radix_digit_emitter
  import sre_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [NUMBER_BITS-1:0] in_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHAR_W-1:0]             out_character,
  output logic                          out_base_error,
  output logic                          out_is_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  logic [TABLE_W-1:0]    symbol_table;
  logic [BASE_LEN_W-1:0] base_length;
  logic                  base_ok;
  sre_cmd_t              cmd;
  sre_sts_t              sts;

  sre_cfg #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .symbol_table (symbol_table),
    .base_length  (base_length),
    .base_ok      (base_ok)
  );

  sre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .base_ok  (base_ok),
    .sts      (sts),
    .cmd      (cmd)
  );

  sre_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_number      (in_number),
    .symbol_table   (symbol_table),
    .base_length    (base_length),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_base_error (out_base_error),
    .out_is_last    (out_is_last)
  );

endmodule

FILE: tb/signed_radix_digit_emitter_test.sv
`timescale 1ns / 1ps

module signed_radix_digit_emitter_test;
  import sre_pkg::*;

  localparam int NUM_W      = 32;
  localparam int TABLE_SIZE = 16;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int TAIL_WAIT  = 200;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              err;
    logic              last;
  } text_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [NUM_W-1:0] in_number;
  logic                   out_valid;
  logic                   out_ready;
  logic [CHAR_W-1:0]      out_character;
  logic                   out_base_error;
  logic                   out_is_last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // local copy of the alphabet registers
  logic [CFG_DATA_W-1:0] alpha_lo;
  logic [CFG_DATA_W-1:0] alpha_hi;
  logic [BASE_LEN_W-1:0] alpha_len;

  text_beat_t pending_chars[$];

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned numbers_sent;
  int unsigned chars_checked;
  int unsigned error_beats;
  int unsigned alphabets_loaded;

  signed_radix_digit_emitter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_base_error (out_base_error),
    .out_is_last    (out_is_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d chars outstanding", cycle_count,
               pending_chars.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic logic [CHAR_W-1:0] symbol_of(input int unsigned k);
    logic [TABLE_W-1:0] tbl;
    tbl = {alpha_hi, alpha_lo};
    return tbl[8*k +: 8];
  endfunction

  function automatic bit alphabet_usable();
    logic [CHAR_W-1:0] c;
    if (alpha_len < 2 || alpha_len > TABLE_SIZE) return 1'b0;
    for (int i = 0; i < alpha_len; i++) begin
      c = symbol_of(i);
      if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < alpha_len; j++)
        if (symbol_of(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the characters one number should produce
  task automatic predict_text(input logic [NUM_W-1:0] num);
    logic [NUM_W-1:0]  mag;
    logic [CHAR_W-1:0] digits[$];
    int unsigned       radix;
    if (!alphabet_usable()) begin
      pending_chars.push_back('{ch: '0, err: 1'b1, last: 1'b1});
      return;
    end
    radix = alpha_len;
    mag = num[NUM_W-1] ? -num : num;
    do begin
      digits.push_front(symbol_of(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (num[NUM_W-1])
      pending_chars.push_back('{ch: CHAR_MINUS, err: 1'b0, last: 1'b0});
    foreach (digits[i])
      pending_chars.push_back('{ch: digits[i], err: 1'b0, last: (i == digits.size() - 1)});
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // compare one output beat with the oldest expected character
  task automatic check_beat();
    text_beat_t want;
    if (pending_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected beat char=%h err=%b last=%b",
                                out_character, out_base_error, out_is_last));
      return;
    end
    want = pending_chars.pop_front();
    chars_checked++;
    if (out_base_error) error_beats++;
    if (out_character !== want.ch)
      report_mismatch($sformatf("character %h, want %h", out_character, want.ch));
    if (out_base_error !== want.err)
      report_mismatch($sformatf("base_error %b, want %b", out_base_error, want.err));
    if (out_is_last !== want.last)
      report_mismatch($sformatf("is_last %b, want %b", out_is_last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_beat();
  end

  // hold the number until accepted; valid stays up for back-to-back beats
  task automatic send_number(input logic [NUM_W-1:0] num);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= num;
    predict_text(num);
    numbers_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every expected character has come out
  task automatic drain_output();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SYMBOLS_LOW:  alpha_lo = val;
      CFG_SYMBOLS_HIGH: alpha_hi = val;
      CFG_BASE_LENGTH:  alpha_len = val[BASE_LEN_W-1:0];
      default: ;
    endcase
  endtask

  // load a full alphabet; caller guarantees the block is idle
  task automatic load_alphabet(input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi,
                               input logic [BASE_LEN_W-1:0] len);
    write_reg(CFG_SYMBOLS_LOW, lo);
    write_reg(CFG_SYMBOLS_HIGH, hi);
    write_reg(CFG_BASE_LENGTH, {{(CFG_DATA_W-BASE_LEN_W){1'b0}}, len});
    cfg_valid <= 1'b0;
    alphabets_loaded++;
  endtask

  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6:          return $urandom_range(600) - 300;
      7:             return 32'h8000_0000 + $urandom_range(3);
      8:             return 32'h7fff_ffff - $urandom_range(3);
      default:       return $urandom_range(1) ? (32'd1 << $urandom_range(31))
                                             : -(32'd1 << $urandom_range(31));
    endcase
  endfunction

  // build a distinct alphabet, then break it now and then
  task automatic load_random_alphabet();
    logic [TABLE_W-1:0] tbl;
    bit                 used[256];
    logic [7:0]         b;
    int unsigned        len;
    int unsigned        i;
    int unsigned        j;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      do b = 8'($urandom_range(255)); while (used[b] || b == CHAR_PLUS || b == CHAR_MINUS);
      used[b] = 1'b1;
      tbl[8*k +: 8] = b;
    end
    len = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : $urandom_range(2, TABLE_SIZE);
    if ($urandom_range(99) < 22) begin
      case ($urandom_range(3))
        0: len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(17, 31);
        1: begin
          i = $urandom_range(len - 1);
          do j = $urandom_range(len - 1); while (j == i);
          tbl[8*j +: 8] = tbl[8*i +: 8];
        end
        2: tbl[8*$urandom_range(len - 1) +: 8] = CHAR_PLUS;
        default: tbl[8*$urandom_range(len - 1) +: 8] = CHAR_MINUS;
      endcase
    end
    load_alphabet(tbl[63:0], tbl[127:64], BASE_LEN_W'(len));
  endtask

  // registers come out of reset as an empty, unusable base
  task automatic test_reset_alphabet();
    send_number(32'd0);
    send_number(-32'sd5);
    drain_output();
  endtask

  task automatic test_decimal_edges();
    load_alphabet("76543210", {48'd0, "98"}, 5'd10);
    send_number(32'd0);
    send_number(32'd1);
    send_number(-32'sd1);
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    send_number(-32'sd10);
    drain_output();
  endtask

  // binary gives the longest text; hex table uses bytes 00 and FF as digits
  task automatic test_wide_radices();
    load_alphabet({48'd0, "10"}, 64'd0, 5'd2);
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    drain_output();
    load_alphabet(64'h0706_0504_0302_0100, 64'hff0e_0d0c_0b0a_0908, 5'd16);
    send_number(-32'sd1);
    send_number(32'h8000_0000);
    drain_output();
    // plus sign beyond the used length does not matter
    load_alphabet("76543210", {8'h2b, 40'd0, "98"}, 5'd3);
    send_number(-32'sd100);
    drain_output();
  endtask

  task automatic test_bad_alphabets();
    load_alphabet("76543210", {48'd0, "98"}, 5'd1);
    send_number(32'd7);
    drain_output();
    load_alphabet("76543210", 64'h4f4e_4d4c_4b4a_3938, 5'd17);
    send_number(32'd7);
    drain_output();
    load_alphabet("76543210", 64'h4f4e_4d4c_4b4a_3938, 5'd31);
    send_number(-32'sd7);
    drain_output();
    load_alphabet("76343210", {48'd0, "98"}, 5'd10);
    send_number(32'd12);
    drain_output();
    load_alphabet({8'h37, 8'h36, 8'h35, 8'h2b, 32'h3332_3130}, {48'd0, "98"}, 5'd10);
    send_number(32'd12);
    drain_output();
    load_alphabet("76543210", {48'd0, 8'h2d, "8"}, 5'd10);
    send_number(32'd12);
    drain_output();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 55, 0, 32};
    stall_tab = '{0, 0, 55, 32};
    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = idle_tab[p];
      out_stall_pct = stall_tab[p];
      for (int g = 0; g < 4; g++) begin
        drain_output();
        load_random_alphabet();
        for (int n = 0; n < 22; n++) begin
          if (n == 11 && $urandom_range(99) < 30) drain_output();
          send_number(pick_number());
        end
      end
    end
    drain_output();
  endtask

  // stop sending until the output is empty, then resume under stalls
  task automatic test_pause_drain();
    in_idle_pct   = 0;
    out_stall_pct = 55;
    load_alphabet("76543210", {48'd0, "98"}, 5'd10);
    send_number(32'h8000_0000);
    send_number(32'd12345);
    drain_output();
    send_number(-32'sd42);
    drain_output();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_number     <= '0;
    out_ready     <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_SYMBOLS_LOW;
    cfg_data      <= '0;
    alpha_lo      = '0;
    alpha_hi      = '0;
    alpha_len     = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_alphabet();
    test_decimal_edges();
    test_wide_radices();
    test_bad_alphabets();
    test_pause_drain();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("converted %0d numbers under %0d alphabets, idle and stall mixes included",
             numbers_sent, alphabets_loaded);
    $display("%0d characters compared, %0d of them bad-base beats, %0d mismatches",
             chars_checked, error_beats, mismatch_count);
    if (mismatch_count == 0 && pending_chars.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/sre_pkg.sv
sv/sre_cfg.sv
sv/sre_ctrl.sv
sv/sre_dp.sv
sv/signed_radix_digit_emitter.sv
tb/signed_radix_digit_emitter_test.sv
